// ===== rtl/core/cst_pkg.sv =====
// Shared types and constants for the cursor sequence table.
// No dependencies; every other file of the block but cst_ram uses this package.
`timescale 1ns / 1ps

package cst_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int KIND_W    = 4;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int CPOS_W    = 6;
    localparam int CNT_W     = 6;

    typedef enum logic [KIND_W-1:0] {
        K_START        = 4'd0,
        K_END          = 4'd1,
        K_LAST         = 4'd2,
        K_ADVANCE      = 4'd3,
        K_RETREAT      = 4'd4,
        K_INSERT       = 4'd5,
        K_INSERT_FRONT = 4'd6,
        K_ATTACH       = 4'd7,
        K_ATTACH_BACK  = 4'd8,
        K_REMOVE_CUR   = 4'd9,
        K_REMOVE_FRONT = 4'd10,
        K_READ_AT      = 4'd11
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_OPEN,
        SH_CLOSE
    } t_shift;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_FETCH,
        S_LOAD
    } t_state;

    // Plan of one request, handed from the decoder to the sequencer.
    typedef struct packed {
        t_shift  shift;
        t_status status;
        logic    val_ok;
    } t_plan;

endpackage

// ===== rtl/core/cst_channels.sv =====
// Request and result channel interfaces of the cursor sequence table.
// Depends on cst_pkg for the field widths.
`timescale 1ns / 1ps

interface cst_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [cst_pkg::KIND_W-1:0]           kind;
    logic signed [cst_pkg::VALUE_W-1:0]   value;
    logic [cst_pkg::POS_W-1:0]            position;

    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

interface cst_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [cst_pkg::STATUS_W-1:0]         status;
    logic signed [cst_pkg::VALUE_W-1:0]   item_value;
    logic [cst_pkg::CPOS_W-1:0]           cursor_pos;
    logic [cst_pkg::CNT_W-1:0]            item_count;
    logic                                 has_item;

    modport source (output valid, status, item_value, cursor_pos, item_count, has_item,
                    input ready);
    modport sink   (input valid, status, item_value, cursor_pos, item_count, has_item,
                    output ready);
endinterface

// ===== rtl/core/cursor_sequence_table.sv =====
// Top level of the cursor sequence table: channels, list state and result register.
// Depends on cst_pkg, cst_channels, cst_decode and cst_seq.
//
//  channel  | dir | payload                                          | handshake
//  ---------+-----+--------------------------------------------------+------------
//  i_req    | in  | kind, value, position                            | valid/ready
//  o_res    | out | status, item_value, cursor_pos, item_count, has_item | valid/ready
//
// One request is worked on at a time. Cursor moves and reads go from acceptance
// through a RAM read to the result load. An insert first walks the entries it moves
// through the single RAM write port, one entry per cycle, and drains the walk, then
// stores the new value, reads the result entry and loads it; a removal does the same
// without the store. The worst case is an insert at the front of DEPTH - 1 entries.
// i_rst_n is synchronous and clears count, cursor and all control; the entry RAM is
// not cleared. A stalled result waits in the output register while the next request
// is taken; that request finishes once the result register is free.
`timescale 1ns / 1ps

module cursor_sequence_table #(
    parameter int DEPTH = cst_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cst_req_if.sink    i_req,
    cst_res_if.source  o_res
);
    import cst_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // List state: entry count and cursor, where DEPTH marks no cursor.
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_cursor;

    // Result of the request in flight, kept from acceptance until the load.
    t_status             r_pl_status;
    logic                r_pl_ok;

    // Output register.
    logic                r_out_valid;
    t_status             r_out_status;
    logic [VALUE_W-1:0]  r_out_value;
    logic [CW-1:0]       r_out_cursor;
    logic [CW-1:0]       r_out_count;
    logic                r_out_has;

    t_plan               plan;
    logic [CW-1:0]       dec_count;
    logic [CW-1:0]       dec_cursor;
    logic [AW-1:0]       dec_pos;
    logic [CW-1:0]       dec_rem;
    logic [AW-1:0]       dec_src;
    logic [AW-1:0]       dec_rd_addr;

    logic                seq_idle;
    logic                seq_load;
    logic                load_ok;
    logic [VALUE_W-1:0]  seq_rdata;
    logic                accept;

    logic [CW+CPOS_W-1:0] cursor_wide;
    logic [CW+CNT_W-1:0]  count_wide;

    cst_decode #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_decode (
        .i_kind     (i_req.kind),
        .i_position (i_req.position),
        .i_count    (r_count),
        .i_cursor   (r_cursor),
        .o_plan     (plan),
        .o_count    (dec_count),
        .o_cursor   (dec_cursor),
        .o_pos      (dec_pos),
        .o_rem      (dec_rem),
        .o_src      (dec_src),
        .o_rd_addr  (dec_rd_addr)
    );

    // A result can be loaded when the output register is empty or being drained.
    assign load_ok = !r_out_valid || o_res.ready;

    cst_seq #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_plan    (plan),
        .i_pos     (dec_pos),
        .i_rem     (dec_rem),
        .i_src     (dec_src),
        .i_rd_addr (dec_rd_addr),
        .i_value   (i_req.value),
        .i_load_ok (load_ok),
        .o_idle    (seq_idle),
        .o_load    (seq_load),
        .o_rdata   (seq_rdata)
    );

    assign i_req.ready = seq_idle;
    assign accept      = i_req.valid && seq_idle;

    // Count and cursor take their new values at acceptance; errors keep the old ones,
    // which the decoder already passes through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count  <= dec_count;
                r_cursor <= dec_cursor;
            end
            if (seq_load && load_ok) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pl_status <= plan.status;
            r_pl_ok     <= plan.val_ok;
        end
        if (seq_load && load_ok) begin
            r_out_status <= r_pl_status;
            r_out_value  <= r_pl_ok ? seq_rdata : '0;
            r_out_cursor <= r_cursor;
            r_out_count  <= r_count;
            r_out_has    <= r_cursor < r_count;
        end
    end

    // Cursor and count leave the block masked to their port widths.
    assign cursor_wide = (CW + CPOS_W)'(r_out_cursor);
    assign count_wide  = (CW + CNT_W)'(r_out_count);

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.item_value = r_out_value;
    assign o_res.cursor_pos = cursor_wide[CPOS_W-1:0];
    assign o_res.item_count = count_wide[CNT_W-1:0];
    assign o_res.has_item   = r_out_has;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(DEPTH)) && (r_cursor <= CW'(DEPTH)))
        else $error("count or cursor beyond the list depth");

    a_state_moves_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count) || r_cursor != $past(r_cursor)))
        |-> $past(accept))
        else $error("list state changed without a request");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(accept)) |->
        (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1) ||
         r_count == $past(r_count) - CW'(1)))
        else $error("count moved by more than one entry");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_load && load_ok) |=> r_out_valid)
        else $error("result lost at load");

endmodule

// ===== rtl/core/cst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cst_decode.sv =====
// Request decoder: checks a request against count and cursor and plans the work.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_decode #(
    parameter int DEPTH = cst_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic [cst_pkg::KIND_W-1:0] i_kind,
    input  logic [cst_pkg::POS_W-1:0]  i_position,
    input  logic [CW-1:0]              i_count,
    input  logic [CW-1:0]              i_cursor,
    output cst_pkg::t_plan             o_plan,
    output logic [CW-1:0]              o_count,
    output logic [CW-1:0]              o_cursor,
    output logic [AW-1:0]              o_pos,
    output logic [CW-1:0]              o_rem,
    output logic [AW-1:0]              o_src,
    output logic [AW-1:0]              o_rd_addr
);
    import cst_pkg::*;

    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic          cur;
    logic          full;
    logic          pos_ok;
    logic [CW-1:0] p;
    logic [CW-1:0] src;

    always_comb begin
        cur       = i_cursor < i_count;
        full      = i_count == CW'(DEPTH);
        pos_ok    = PW'(i_position) < PW'(i_count);
        o_cursor  = i_cursor;
        o_count   = i_count;
        p         = '0;
        o_plan    = '{shift: SH_NONE, status: ST_OK, val_ok: 1'b0};

        unique case (t_kind'(i_kind))
            K_START:   o_cursor = '0;
            K_END: begin
                if (i_count == '0) o_plan.status = ST_EMPTY;
                else               o_cursor = i_count - CW'(1);
            end
            K_LAST:    o_cursor = CW'(DEPTH - 1);
            K_ADVANCE: begin
                if (!cur) o_plan.status = ST_EMPTY;
                else      o_cursor = i_cursor + CW'(1);
            end
            K_RETREAT: begin
                if (!cur)                 o_plan.status = ST_EMPTY;
                else if (i_cursor == '0)  o_cursor = CW'(DEPTH);
                else                      o_cursor = i_cursor - CW'(1);
            end
            K_INSERT, K_INSERT_FRONT, K_ATTACH, K_ATTACH_BACK: begin
                if (full) begin
                    o_plan.status = ST_FULL;
                end else begin
                    o_plan.shift = SH_OPEN;
                    o_count      = i_count + CW'(1);
                    priority case (t_kind'(i_kind))
                        K_INSERT: begin
                            o_cursor = cur ? i_cursor : '0;
                            p        = o_cursor;
                        end
                        K_INSERT_FRONT: begin
                            o_cursor = cur ? i_cursor : '0;
                            p        = '0;
                        end
                        K_ATTACH: begin
                            o_cursor = cur ? i_cursor + CW'(1) : i_count;
                            p        = o_cursor;
                        end
                        default: begin
                            o_cursor = cur ? i_cursor : i_count;
                            p        = i_count;
                        end
                    endcase
                end
            end
            K_REMOVE_CUR, K_REMOVE_FRONT: begin
                if (!cur) begin
                    o_plan.status = ST_EMPTY;
                end else begin
                    o_plan.shift = SH_CLOSE;
                    o_count      = i_count - CW'(1);
                    p            = (t_kind'(i_kind) == K_REMOVE_CUR) ? i_cursor : '0;
                end
            end
            K_READ_AT: begin
                if (!pos_ok) o_plan.status = ST_EMPTY;
            end
            default: ;
        endcase

        // Opening walks down from the last entry; closing walks up from the gap.
        if (o_plan.shift == SH_OPEN) begin
            o_rem = i_count - p;
            src   = i_count - CW'(1);
        end else begin
            o_rem = (o_plan.shift == SH_CLOSE) ? i_count - p - CW'(1) : '0;
            src   = p + CW'(1);
        end
        o_pos = AW'(p);
        o_src = AW'(src);

        if (t_kind'(i_kind) == K_READ_AT) begin
            o_plan.val_ok = pos_ok;
            o_rd_addr     = AW'(i_position);
        end else begin
            o_plan.val_ok = o_cursor < o_count;
            o_rd_addr     = AW'(o_cursor);
        end
    end

endmodule

// ===== rtl/core/cst_seq.sv =====
// Memory sequencer: shifts entries, stores the new value and reads the result entry.
// Depends on cst_pkg and cst_ram.
`timescale 1ns / 1ps

module cst_seq #(
    parameter int DEPTH = cst_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  cst_pkg::t_plan              i_plan,
    input  logic [AW-1:0]               i_pos,
    input  logic [CW-1:0]               i_rem,
    input  logic [AW-1:0]               i_src,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic [cst_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_load_ok,
    output logic                        o_idle,
    output logic                        o_load,
    output logic [cst_pkg::VALUE_W-1:0] o_rdata
);
    import cst_pkg::*;

    t_state               r_state, n_state;
    t_shift               r_shift;
    logic [CW-1:0]        r_rem;
    logic [AW-1:0]        r_src;
    logic [AW-1:0]        r_dst;
    logic                 r_pend;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_rd_addr;
    logic [VALUE_W-1:0]   r_value;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [VALUE_W-1:0]   wdata;
    logic                 re;
    logic [AW-1:0]        raddr;
    logic [VALUE_W-1:0]   rdata;

    cst_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = (i_plan.shift == SH_NONE) ? S_FETCH : S_SHIFT;
            end
            S_SHIFT: begin
                if (r_rem == '0 && !r_pend) n_state = (r_shift == SH_OPEN) ? S_PUT : S_FETCH;
            end
            S_PUT:   n_state = S_FETCH;
            S_FETCH: n_state = S_LOAD;
            S_LOAD: begin
                if (i_load_ok) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        we     = 1'b0;
        waddr  = r_dst;
        wdata  = rdata;
        re     = 1'b0;
        raddr  = r_src;
        o_idle = 1'b0;
        o_load = 1'b0;
        unique case (r_state)
            S_IDLE:  o_idle = 1'b1;
            S_SHIFT: begin
                we = r_pend;
                re = r_rem != '0;
            end
            S_PUT: begin
                we    = 1'b1;
                waddr = r_pos;
                wdata = r_value;
            end
            S_FETCH: begin
                re    = 1'b1;
                raddr = r_rd_addr;
            end
            S_LOAD:  o_load = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start) begin
                r_rem  <= i_rem;
                r_pend <= 1'b0;
            end else if (r_state == S_SHIFT) begin
                r_pend <= r_rem != '0;
                if (r_rem != '0) r_rem <= r_rem - CW'(1);
            end
        end
    end

    // Payload of the walk; the read of one step feeds the write of the next.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_shift   <= i_plan.shift;
            r_src     <= i_src;
            r_pos     <= i_pos;
            r_rd_addr <= i_rd_addr;
            r_value   <= i_value;
        end else if (r_state == S_SHIFT && r_rem != '0) begin
            r_dst <= (r_shift == SH_OPEN) ? r_src + AW'(1) : r_src - AW'(1);
            r_src <= (r_shift == SH_OPEN) ? r_src - AW'(1) : r_src + AW'(1);
        end
    end

    assign o_rdata = rdata;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend && r_rem != '0) |-> (r_dst != r_src))
        else $error("shift reads and writes the same entry");

    a_put_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (!r_pend && r_rem == '0 && r_shift == SH_OPEN))
        else $error("new value stored before the shift drained");

    a_fetch_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> !r_pend)
        else $error("result read while a shift write is pending");

endmodule

// ===== bench/cursor_sequence_table_tb.sv =====
// Self-checking testbench for the cursor sequence table: random and directed list requests.
// Depends on cst_pkg, the cst_req_if / cst_res_if interfaces and cursor_sequence_table.
`timescale 1ns / 1ps

module cursor_sequence_table_tb;
    import cst_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // Kind codes above read_at carry no operation; the block answers them with a plain status.
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 4'd12;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 4'd15;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    // Longest idle gap either side draws per request.
    localparam int GAP_MAX = 17;
    // The receiver holds off once for this long, after this many results.
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 80;
    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 3000;
    // Settling time after the last expected result, derived from the worst-case request time.
    localparam int DRAIN_CYCLES = 2 * (DEPTH + 5);
    // Random requests that carry an operation.
    localparam int RANDOM_REQUESTS = 500;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] item_value;
        logic [CPOS_W-1:0]         cursor_pos;
        logic [CNT_W-1:0]          item_count;
        logic                      has_item;
    } list_result_t;

    // The scoreboard keeps its own copy of the list and cursor. Every accepted request is
    // applied to that copy, and the result it must produce is queued in arrival order.
    class list_scoreboard;
        logic signed [VALUE_W-1:0] entries [DEPTH];
        int unsigned               count;
        int unsigned               cursor;
        list_result_t              pending_results [$];
        int                        errors;

        function new();
            count  = 0;
            cursor = 0;
            errors = 0;
        endfunction

        function void flag_error(string what);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] ERROR: %s", $realtime, what);
        endfunction

        // Make room at index p by moving the tail up one place, then store v there.
        function void open_slot(int unsigned p, logic signed [VALUE_W-1:0] v);
            for (int unsigned i = count; i > p; i--)
                entries[i] = entries[i - 1];
            entries[p] = v;
            count++;
        endfunction

        // Drop index p by moving the tail down one place.
        function void close_slot(int unsigned p);
            for (int unsigned i = p; i + 1 < count; i++)
                entries[i] = entries[i + 1];
            count--;
        endfunction

        function list_result_t step_list(logic [KIND_W-1:0] kind,
                                         logic signed [VALUE_W-1:0] value,
                                         logic [POS_W-1:0] pos);
            list_result_t              r;
            bit                        cur;
            bit                        full;
            bit                        use_read;
            t_status                   status;
            logic signed [VALUE_W-1:0] read_val;

            cur      = cursor < count;
            full     = count >= DEPTH;
            status   = ST_OK;
            use_read = 1'b0;
            read_val = '0;

            // An error leaves list, count and cursor untouched.
            case (kind)
                K_START: cursor = 0;
                K_END: begin
                    if (count == 0) status = ST_EMPTY;
                    else cursor = count - 1;
                end
                K_LAST: cursor = DEPTH - 1;
                K_ADVANCE: begin
                    if (!cur) status = ST_EMPTY;
                    else cursor++;
                end
                K_RETREAT: begin
                    // Stepping back from the first entry leaves no cursor at all.
                    if (!cur) status = ST_EMPTY;
                    else cursor = (cursor == 0) ? DEPTH : cursor - 1;
                end
                K_INSERT: begin
                    if (full) status = ST_FULL;
                    else begin
                        if (!cur) cursor = 0;
                        open_slot(cursor, value);
                    end
                end
                K_INSERT_FRONT: begin
                    if (full) status = ST_FULL;
                    else begin
                        if (!cur) cursor = 0;
                        open_slot(0, value);
                    end
                end
                K_ATTACH: begin
                    if (full) status = ST_FULL;
                    else begin
                        cursor = cur ? cursor + 1 : count;
                        open_slot(cursor, value);
                    end
                end
                K_ATTACH_BACK: begin
                    if (full) status = ST_FULL;
                    else begin
                        if (!cur) cursor = count;
                        open_slot(count, value);
                    end
                end
                K_REMOVE_CUR: begin
                    if (!cur) status = ST_EMPTY;
                    else close_slot(cursor);
                end
                K_REMOVE_FRONT: begin
                    if (!cur) status = ST_EMPTY;
                    else close_slot(0);
                end
                K_READ_AT: begin
                    use_read = 1'b1;
                    if (pos < count) read_val = entries[pos];
                    else status = ST_EMPTY;
                end
                default: ;
            endcase

            cur          = cursor < count;
            r.status     = status;
            r.item_value = use_read ? read_val : (cur ? entries[cursor] : '0);
            r.cursor_pos = CPOS_W'(cursor);
            r.item_count = CNT_W'(count);
            r.has_item   = cur;
            return r;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            pending_results.push_back(step_list(kind, value, pos));
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected result st=%0d val=%0d cur=%0d cnt=%0d has=%0b",
                                     got.status, got.item_value, got.cursor_pos,
                                     got.item_count, got.has_item));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.item_value !== want.item_value ||
                got.cursor_pos !== want.cursor_pos || got.item_count !== want.item_count ||
                got.has_item !== want.has_item)
                flag_error($sformatf({"result mismatch: expected st=%0d val=%0d cur=%0d ",
                                      "cnt=%0d has=%0b, got st=%0d val=%0d cur=%0d cnt=%0d ",
                                      "has=%0b"},
                                     want.status, want.item_value, want.cursor_pos,
                                     want.item_count, want.has_item, got.status,
                                     got.item_value, got.cursor_pos, got.item_count,
                                     got.has_item));
        endfunction

        // Anything still queued at the end was never answered by the block.
        function void close_out();
            if (pending_results.size() != 0)
                flag_error($sformatf("%0d results never arrived", pending_results.size()));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    cst_req_if req_ch ();
    cst_res_if res_ch ();

    cursor_sequence_table #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    always #1 clk = ~clk;

    list_scoreboard sb;
    int             requests_sent = 0;
    int             results_seen  = 0;

    // Pick a value, leaning on the extremes so both ends of the signed range are stored often.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Pick a read position: usually a stored entry, sometimes anywhere in the field range.
    function automatic logic [POS_W-1:0] pick_position();
        if (sb.count != 0 && $urandom_range(0, 9) < 7)
            return POS_W'($urandom_range(0, sb.count - 1));
        return POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // Offer one request after a random gap and return once it has been accepted. Valid is only
    // lowered when a gap follows, so back-to-back requests keep it high through the edge.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        int gap;
        // Every fourth stretch of forty requests runs without gaps.
        gap = ((requests_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.value    <= value;
        req_ch.position <= pos;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        sb.note_request(kind, value, pos);
        requests_sent++;
    endtask

    // Directed opening: every error on an empty list, both value extremes, each cursor move,
    // retreating off the first entry, attaching with no current entry, removing the last entry,
    // reads in and out of range, and the spare kind codes.
    task automatic run_directed();
        send_request(K_END, '0, '0);
        send_request(K_ADVANCE, '0, '0);
        send_request(K_RETREAT, '0, '0);
        send_request(K_REMOVE_CUR, '0, '0);
        send_request(K_REMOVE_FRONT, '0, '0);
        send_request(K_READ_AT, '0, '0);
        send_request(K_LAST, '0, '0);
        send_request(K_INSERT, VAL_MAX, '0);
        send_request(K_INSERT_FRONT, VAL_MIN, '0);
        send_request(K_ATTACH, '0, '0);
        send_request(K_ATTACH_BACK, -1, '0);
        send_request(K_READ_AT, '0, 5'd31);
        send_request(K_READ_AT, '0, 5'd3);
        send_request(K_START, '0, '0);
        send_request(K_RETREAT, '0, '0);
        send_request(K_ATTACH_BACK, 32'sh5555_AAAA, '0);
        send_request(K_ADVANCE, '0, '0);
        send_request(K_ATTACH, 32'shAAAA_5555, '0);
        send_request(K_END, '0, '0);
        send_request(K_REMOVE_CUR, '0, '0);
        send_request(K_INSERT_FRONT, 32'sh1234_5678, '0);
        send_request(K_REMOVE_FRONT, '0, '0);
        send_request(KIND_SPARE_FIRST, $urandom, POS_W'($urandom));
        send_request(KIND_SPARE_LAST, $urandom, POS_W'($urandom));
        send_request(K_READ_AT, '0, '0);
    endtask

    // Random part, built from phases. A fill phase grows the list until it is full and then
    // knocks on the full list; a drain phase empties it, putting the cursor back on an entry
    // whenever it falls off; a mixed phase draws any kind. Spare kinds are not counted.
    task automatic run_random();
        int                        done;
        int                        phase;
        int                        span;
        logic [KIND_W-1:0]         kind;
        done = 0;
        while (done < RANDOM_REQUESTS) begin
            phase = $urandom_range(0, 9);
            if (phase < 3) begin
                while (sb.count < DEPTH) begin
                    if ($urandom_range(0, 99) < 85)
                        kind = KIND_W'($urandom_range(K_INSERT, K_ATTACH_BACK));
                    else
                        kind = KIND_W'($urandom_range(K_START, K_RETREAT));
                    send_request(kind, pick_value(), pick_position());
                    done++;
                end
                span = $urandom_range(1, 4);
                repeat (span) begin
                    kind = KIND_W'($urandom_range(K_START, K_READ_AT));
                    send_request(kind, pick_value(), pick_position());
                    done++;
                end
            end else if (phase < 6) begin
                while (sb.count > 0) begin
                    if (sb.cursor >= sb.count)
                        kind = $urandom_range(0, 1) ? K_START : K_END;
                    else if ($urandom_range(0, 99) < 75)
                        kind = $urandom_range(0, 1) ? K_REMOVE_CUR : K_REMOVE_FRONT;
                    else
                        case ($urandom_range(0, 2))
                            0:       kind = K_ADVANCE;
                            1:       kind = K_RETREAT;
                            default: kind = K_READ_AT;
                        endcase
                    send_request(kind, pick_value(), pick_position());
                    done++;
                end
                kind = $urandom_range(0, 1) ? K_REMOVE_CUR : K_REMOVE_FRONT;
                send_request(kind, pick_value(), pick_position());
                done++;
            end else begin
                span = $urandom_range(10, 40);
                repeat (span) begin
                    if ($urandom_range(0, 99) < 3) begin
                        kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
                        send_request(kind, $urandom, POS_W'($urandom));
                    end else begin
                        kind = KIND_W'($urandom_range(K_START, K_READ_AT));
                        send_request(kind, pick_value(), pick_position());
                        done++;
                    end
                end
            end
        end
    endtask

    // Receiver: a random gap before each result, stretches with no gaps, and one long hold-off
    // during which the sender keeps offering requests until the block stops taking them.
    initial begin : result_sink
        int           gap;
        bit           held;
        list_result_t got;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            gap = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, GAP_MAX);
            if (!held && results_seen == HOLD_AT) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
            got.status     = res_ch.status;
            got.item_value = res_ch.item_value;
            got.cursor_pos = res_ch.cursor_pos;
            got.item_count = res_ch.item_count;
            got.has_item   = res_ch.has_item;
            sb.check_result(got);
            results_seen++;
        end
    end

    // Watchdog: ends the run if neither channel completes a handshake for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : main_flow
        sb = new();
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.kind     <= '0;
        req_ch.value    <= '0;
        req_ch.position <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        // The last request was taken at this edge; nothing else is driven on valid here.
        req_ch.valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        // Give the block time to show any stray result after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cst_pkg.sv
rtl/core/cst_channels.sv
rtl/core/cst_ram.sv
rtl/core/cst_decode.sv
rtl/core/cst_seq.sv
rtl/core/cursor_sequence_table.sv
bench/cursor_sequence_table_tb.sv
